// ===== src/pef_pkg.sv =====
// Shared types, constants and helper functions for the Prewitt edge filter.
`timescale 1ns / 1ps

package pef_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIXEL_BITS = 8;

    localparam int CFG_W   = 11;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SUM_W   = PIXEL_BITS + 2;
    localparam int GRAD_W  = SUM_W + 1;
    localparam int INDEX_W = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // Register indexes of the configuration port.
    typedef enum logic [INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_EDGE_MODE    = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_VERTICAL   = 1'b0,
        MODE_HORIZONTAL = 1'b1
    } edge_mode_t;

    // Active configuration: the index of the last column and last row.
    typedef struct packed {
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
        edge_mode_t       mode;
    } cfg_t;

    // One pixel after the line stores, with its position flags.
    typedef struct packed {
        logic                  valid;
        logic                  produce;
        logic                  last;
        logic [PIXEL_BITS-1:0] top;
        logic [PIXEL_BITS-1:0] mid;
        logic [PIXEL_BITS-1:0] bot;
    } stage_t;

    // Clamps a size to 3..MAX_WIDTH and returns the index of the last column.
    function automatic logic [COL_W-1:0] width_last(input logic [CFG_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v < CFG_W'(3)) begin
            r = COL_W'(2);
        end
        else if (v > CFG_W'(MAX_WIDTH)) begin
            r = COL_W'(MAX_WIDTH - 1);
        end
        else begin
            r = COL_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

    // Clamps a size to 3..MAX_HEIGHT and returns the index of the last row.
    function automatic logic [ROW_W-1:0] height_last(input logic [CFG_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v < CFG_W'(3)) begin
            r = ROW_W'(2);
        end
        else if (v > CFG_W'(MAX_HEIGHT)) begin
            r = ROW_W'(MAX_HEIGHT - 1);
        end
        else begin
            r = ROW_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

// ===== src/pef_cfg_regs.sv =====
// Configuration registers of the Prewitt edge filter.
`timescale 1ns / 1ps

module pef_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pef_pkg::INDEX_W-1:0] cfg_index,
    input  logic [pef_pkg::CFG_W-1:0]  cfg_data,
    output pef_pkg::cfg_t              cfg
);
    import pef_pkg::*;

    logic [COL_W-1:0] col_last_reg;
    logic [ROW_W-1:0] row_last_reg;
    edge_mode_t       mode_reg;

    assign cfg_ready = 1'b1;

    // Sizes are stored already clamped, as the index of the last column or row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_last_reg <= width_last(WIDTH_RESET);
            row_last_reg <= height_last(HEIGHT_RESET);
            mode_reg     <= MODE_VERTICAL;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  col_last_reg <= width_last(cfg_data);
                REG_IMAGE_HEIGHT: row_last_reg <= height_last(cfg_data);
                REG_EDGE_MODE:    mode_reg     <= edge_mode_t'(cfg_data[0]);
                default:          ;
            endcase
        end
    end

    assign cfg.col_last = col_last_reg;
    assign cfg.row_last = row_last_reg;
    assign cfg.mode     = mode_reg;

endmodule

// ===== src/pef_line_buffer.sv =====
// Raster position counters and the two line stores of the Prewitt edge filter.
`timescale 1ns / 1ps

module pef_line_buffer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pef_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pef_pkg::PIXEL_BITS-1:0] pixel,
    input  logic                          frame_start,
    input  logic                          s1_adv,
    output pef_pkg::stage_t               s1
);
    import pef_pkg::*;

    logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];

    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic [COL_W-1:0]      cur_col;
    logic [ROW_W-1:0]      cur_row;
    logic                  accept;
    logic                  bypass;

    logic                  s1_valid_reg;
    logic                  s1_produce_reg;
    logic                  s1_last_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [PIXEL_BITS-1:0] top_reg;
    logic [PIXEL_BITS-1:0] mid_reg;
    logic [PIXEL_BITS-1:0] bot_reg;

    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign cur_col = frame_start ? '0 : col_reg;
    assign cur_row = frame_start ? '0 : row_reg;

    always_comb
    begin
        if (cur_col >= cfg.col_last) begin
            col_next = '0;
            row_next = (cur_row >= cfg.row_last) ? '0 : cur_row + ROW_W'(1);
        end
        else begin
            col_next = cur_col + COL_W'(1);
            row_next = cur_row;
        end
    end

    // The upper store is written when the held pixel moves on; a new pixel
    // reading the same column in that cycle takes the value being written.
    assign bypass = s1_adv && (s1_col_reg == cur_col);

    always_ff @(posedge clk)
    begin
        if (accept) begin
            lower_mem[cur_col] <= pixel;
            mid_reg            <= lower_mem[cur_col];
            top_reg            <= bypass ? mid_reg : upper_mem[cur_col];
            bot_reg            <= pixel;
            s1_col_reg         <= cur_col;
            s1_produce_reg     <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
            s1_last_reg        <= (cur_row >= cfg.row_last) && (cur_col >= cfg.col_last);
        end
        if (s1_adv) begin
            upper_mem[s1_col_reg] <= mid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    assign s1.valid   = s1_valid_reg;
    assign s1.produce = s1_produce_reg;
    assign s1.last    = s1_last_reg;
    assign s1.top     = top_reg;
    assign s1.mid     = mid_reg;
    assign s1.bot     = bot_reg;

endmodule

// ===== src/pef_window.sv =====
// Window registers, Prewitt kernel and result register of the edge filter.
`timescale 1ns / 1ps

module pef_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pef_pkg::cfg_t                 cfg,
    input  pef_pkg::stage_t               s1,
    output logic                          s1_adv,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [pef_pkg::GRAD_W-1:0] gradient,
    output logic                          frame_last
);
    import pef_pkg::*;

    // Index 0..2: column c-2 top, mid, bottom; index 3..5: column c-1.
    logic [PIXEL_BITS-1:0] win_reg [6];
    logic [SUM_W-1:0]      pos_sum;
    logic [SUM_W-1:0]      neg_sum;
    logic [GRAD_W-1:0]     grad_next;
    logic                  out_valid_reg;
    logic [GRAD_W-1:0]     gradient_reg;
    logic                  frame_last_reg;

    assign s1_adv = s1.valid && (!s1.produce || !out_valid_reg || out_ready);

    always_comb
    begin
        case (cfg.mode)
            MODE_VERTICAL:
            begin
                pos_sum = SUM_W'(win_reg[0]) + SUM_W'(win_reg[1]) + SUM_W'(win_reg[2]);
                neg_sum = SUM_W'(s1.top) + SUM_W'(s1.mid) + SUM_W'(s1.bot);
            end
            MODE_HORIZONTAL:
            begin
                pos_sum = SUM_W'(win_reg[0]) + SUM_W'(win_reg[3]) + SUM_W'(s1.top);
                neg_sum = SUM_W'(win_reg[2]) + SUM_W'(win_reg[5]) + SUM_W'(s1.bot);
            end
            default:
            begin
                pos_sum = '0;
                neg_sum = '0;
            end
        endcase
        grad_next = GRAD_W'(pos_sum) - GRAD_W'(neg_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= s1.top;
            win_reg[4] <= s1.mid;
            win_reg[5] <= s1.bot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1.produce) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1.produce) begin
            gradient_reg   <= grad_next;
            frame_last_reg <= s1.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gradient   = $signed(gradient_reg);
    assign frame_last = frame_last_reg;

endmodule

// ===== src/prewitt_edge_filter_3x3_top.sv =====
// Top level of the 3x3 Prewitt edge filter.
//
// The block takes a raster stream of 8-bit pixels, one request per pixel, and
// returns one signed 11-bit gradient for every pixel at row 2 or later and
// column 2 or later, so a frame of W by H pixels gives (W-2) by (H-2) results,
// the last of them marked by frame_last. A pixel with frame_start set restarts
// the frame at row 0, column 0; a frame that runs to its end wraps by itself.
// Edge mode 0 gives the left column sum minus the right column sum, mode 1 the
// top row sum minus the bottom row sum. Width and height are clamped to
// 3..1024. The block accepts one pixel per clock cycle while no result waits
// on the output side. The edge that accepts a pixel also captures the position
// flags and the registered reads of the two 1024-entry line stores; when the
// first stage moves on, the window and kernel sum are loaded into the result
// register. A result that waits on the output side holds the next producing
// pixel in the first stage, and the input is ready again in the cycle that
// the waiting result is taken. The line stores need no clearing after reset,
// so pixels are accepted from the first cycle.
// Configuration writes are accepted in every cycle but should only be made
// while the block is idle. A pixel that produces no result never waits for
// the output side.
`timescale 1ns / 1ps

module prewitt_edge_filter_3x3_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pef_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [pef_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pef_pkg::PIXEL_BITS-1:0] pixel,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [pef_pkg::GRAD_W-1:0] gradient,
    output logic                          frame_last
);
    import pef_pkg::*;

    cfg_t   cfg;
    stage_t s1;
    logic   s1_adv;

    // Configuration registers, held as the indexes of the last column and row.
    pef_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // First stage: position tracking and the two line stores, giving the
    // new three-pixel column of the window.
    pef_line_buffer u_lines (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .s1_adv      (s1_adv),
        .s1          (s1)
    );

    // Second stage: the two older window columns, the kernel sum, and the
    // result register that separates the output handshake from the input.
    pef_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s1         (s1),
        .s1_adv     (s1_adv),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .gradient   (gradient),
        .frame_last (frame_last)
    );

endmodule

// ===== src/pef_checker.sv =====
// Port-level assertions for the Prewitt edge filter and their binding.
`timescale 1ns / 1ps

module pef_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          cfg_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [pef_pkg::GRAD_W-1:0] gradient,
    input  logic                          frame_last
);
    import pef_pkg::*;

    localparam logic signed [GRAD_W-1:0] GRAD_MAX = GRAD_W'(765);
    localparam logic signed [GRAD_W-1:0] GRAD_MIN = -GRAD_W'(765);

    // A waiting result holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gradient) && $stable(frame_last))
    else $error("result changed while waiting");

    // The kernel sum of 8-bit pixels stays within three full-scale pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gradient <= GRAD_MAX) && (gradient >= GRAD_MIN))
    else $error("gradient out of range");

    // With the result register empty, nothing blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with empty output");

    // Configuration requests are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
    else $error("configuration port not ready");

endmodule

bind prewitt_edge_filter_3x3_top pef_checker u_pef_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .gradient   (gradient),
    .frame_last (frame_last)
);

// ===== tb/prewitt_checker.sv =====
// Checker that predicts and compares the gradients of the 3x3 Prewitt edge filter.
`timescale 1ns / 1ps

module prewitt_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pef_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [pef_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [pef_pkg::PIXEL_BITS-1:0]      pixel,
    input  logic                                frame_start,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [pef_pkg::GRAD_W-1:0]   gradient,
    input  logic                                frame_last,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  checked,
    output int                                  frame_ends
);
    import pef_pkg::*;

    typedef struct {
        logic signed [GRAD_W-1:0] gradient;
        logic                     frame_last;
    } grad_result_t;

    logic [CFG_W-1:0]      width_reg;
    logic [CFG_W-1:0]      height_reg;
    edge_mode_t            mode_reg;
    logic [PIXEL_BITS-1:0] row_store_upper [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] row_store_lower [MAX_WIDTH];
    // Entries 0..2 hold column c-2 (top, mid, bottom), entries 3..5 column c-1.
    logic [PIXEL_BITS-1:0] window [6];
    int unsigned           col_pos;
    int unsigned           row_pos;
    grad_result_t          gradient_q [$];

    function automatic int unsigned clamped_size(input logic [CFG_W-1:0] v,
                                                 input int unsigned hi);
        if (v < CFG_W'(3))
        begin
            return 3;
        end
        if (v > hi)
        begin
            return hi;
        end
        return 32'(v);
    endfunction

    // Advances the filter by one pixel and queues the gradient it produces, if any.
    task automatic predict_gradient(input logic [PIXEL_BITS-1:0] px, input logic fs);
        int unsigned           w;
        int unsigned           h;
        logic [PIXEL_BITS-1:0] top;
        logic [PIXEL_BITS-1:0] mid;
        int                    s;
        grad_result_t          r;
        w = clamped_size(width_reg, MAX_WIDTH);
        h = clamped_size(height_reg, MAX_HEIGHT);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        top = row_store_upper[col_pos];
        mid = row_store_lower[col_pos];
        row_store_upper[col_pos] = mid;
        row_store_lower[col_pos] = px;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            if (mode_reg == MODE_VERTICAL)
            begin
                s = int'(window[0]) + int'(window[1]) + int'(window[2])
                    - int'(top) - int'(mid) - int'(px);
            end
            else
            begin
                s = int'(window[0]) + int'(window[3]) + int'(top)
                    - int'(window[2]) - int'(window[5]) - int'(px);
            end
            r.gradient   = s[GRAD_W-1:0];
            r.frame_last = (row_pos >= h - 1) && (col_pos >= w - 1);
            gradient_q.push_back(r);
        end
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = px;
        if (col_pos >= w - 1)
        begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grad_result_t want;
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            mode_reg   = MODE_VERTICAL;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                row_store_upper[i] = '0;
                row_store_lower[i] = '0;
            end
            for (int i = 0; i < 6; i++)
            begin
                window[i] = '0;
            end
            col_pos    = 0;
            row_pos    = 0;
            gradient_q.delete();
            mismatches = 0;
            checked    = 0;
            frame_ends = 0;
            pending    = 0;
        end
        else
        begin
            // A result leaves only after its pixel is registered, so compare before queueing.
            if (out_valid && out_ready)
            begin
                if (gradient_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, gradient %0d frame_last %0b",
                             $time, gradient, frame_last);
                    mismatches++;
                end
                else
                begin
                    want = gradient_q.pop_front();
                    checked++;
                    if (frame_last === 1'b1)
                    begin
                        frame_ends++;
                    end
                    if (gradient !== want.gradient)
                    begin
                        $display("%0t: gradient mismatch, expected %0d, actual %0d",
                                 $time, want.gradient, gradient);
                        mismatches++;
                    end
                    if (frame_last !== want.frame_last)
                    begin
                        $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                                 $time, want.frame_last, frame_last);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                    REG_EDGE_MODE:    mode_reg   = edge_mode_t'(cfg_data[0]);
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_gradient(pixel, frame_start);
            end
            pending = gradient_q.size();
        end
    end

endmodule

// ===== tb/tb_prewitt_edge_filter_3x3_top.sv =====
// Testbench top for the 3x3 Prewitt edge filter: stimulus, reset and verdict.
`timescale 1ns / 1ps

module tb_prewitt_edge_filter_3x3_top;
    import pef_pkg::*;

    localparam int     RESET_CYCLES = 10;
    localparam int     RANDOM_ITEMS = 540;
    // A pixel that gives no result leaves the first stage in the cycle after it is
    // accepted; the rest of the drain is margin.
    localparam int     DRAIN_CYCLES = 4;
    localparam int     END_CYCLES   = 10;
    localparam longint TIMEOUT_NS   = 64'd5_000_000;
    // Index 3 maps to no register; the block must ignore a write to it.
    localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [INDEX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [PIXEL_BITS-1:0]      pixel;
    logic                       frame_start;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [GRAD_W-1:0]   gradient;
    logic                       frame_last;

    int mismatches;
    int pending;
    int checked;
    int frame_ends;

    // When steady is set, neither side idles; it is used for the last part of the run.
    bit steady = 1'b0;
    int stall_left = 0;
    int pixels_sent = 0;
    int settings_used = 0;
    // Effective width that the line stores were last filled at.
    int cur_width = 640;

    always #5 clk = ~clk;

    prewitt_edge_filter_3x3_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .gradient    (gradient),
        .frame_last  (frame_last)
    );

    prewitt_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .gradient    (gradient),
        .frame_last  (frame_last),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .frame_ends  (frame_ends)
    );

    // The result side stalls in random bursts, and never in the last part.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (steady)
            begin
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Writes one register through the configuration channel and waits for the request
    // to be taken.
    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drops the pixel request and waits until every expected gradient has come out,
    // then lets the pipeline empty itself of pixels that give no result.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Sends one pixel request, sometimes after a gap, and waits until it is accepted.
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] px, input logic fs);
        int gap;
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        pixel       <= px;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    // Programs all three registers while the block is idle. The mode word carries
    // random upper bits, which the block must ignore. A raise of the width means
    // the line stores hold columns never written in this frame, so the caller must
    // restart the frame; restart reports that, and frame_px the frame size.
    task automatic apply_setting(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                                 input edge_mode_t mode, output bit restart,
                                 output int frame_px);
        int w_eff;
        int h_eff;
        wait_idle();
        w_eff = (w_raw < 3) ? 3 : ((w_raw > MAX_WIDTH) ? MAX_WIDTH : int'(w_raw));
        h_eff = (h_raw < 3) ? 3 : ((h_raw > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_raw));
        write_reg(REG_IMAGE_WIDTH, w_raw);
        write_reg(REG_IMAGE_HEIGHT, h_raw);
        write_reg(REG_EDGE_MODE, {10'($urandom_range(0, 1023)), 1'(mode)});
        restart   = (w_eff > cur_width);
        cur_width = w_eff;
        frame_px  = w_eff * h_eff;
        settings_used++;
    endtask

    // Streams n random pixels. The first may restart the frame; with noise on, a
    // stray frame_start now and then breaks the frame in the middle.
    task automatic run_pixels(input int n, input bit first_fs, input bit noisy);
        logic [PIXEL_BITS-1:0] px;
        logic                  fs;
        for (int i = 0; i < n; i++)
        begin
            fs = (i == 0 && first_fs) || (noisy && $urandom_range(0, 79) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                px = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            end
            else
            begin
                px = 8'($urandom_range(0, 255));
            end
            send_pixel(px, fs);
        end
    endtask

    initial
    begin
        bit               restart;
        int               frame_px;
        int               random_sent;
        int               n;
        int               sel;
        bit               special_done;
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        edge_mode_t       mode;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_IMAGE_WIDTH;
        cfg_data    = '0;
        in_valid    = 1'b0;
        pixel       = '0;
        frame_start = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A 3x3 frame with a bright left column gives the largest
        // vertical gradient; the next frame follows without frame_start, so the
        // wrap at the end of a frame is seen, and its bright right column gives
        // the most negative gradient. Each frame has one result, marked last.
        apply_setting(11'd3, 11'd3, MODE_VERTICAL, restart, frame_px);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                send_pixel((c == 0) ? 8'd255 : ((c == 1) ? 8'd128 : 8'd0), r == 0 && c == 0);
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                send_pixel((c == 0) ? 8'd0 : ((c == 1) ? 8'd77 : 8'd255), 1'b0);
            end
        end
        // Horizontal kernel with a bright top row.
        apply_setting(11'd3, 11'd3, MODE_HORIZONTAL, restart, frame_px);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                send_pixel((r == 0) ? 8'd255 : ((r == 1) ? 8'd1 : 8'd0), r == 0 && c == 0);
            end
        end
        // Sizes below the minimum are clamped to three, and a write to the unused
        // index must change nothing.
        apply_setting(11'd0, 11'd2, MODE_VERTICAL, restart, frame_px);
        write_reg(REG_UNUSED, 11'h7FF);
        run_pixels(frame_px, 1'b1, 1'b0);

        // Random part: mostly whole frames at small sizes with random content,
        // partial frames that the next setting cuts short, and stray restarts.
        random_sent  = 0;
        special_done = 1'b0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (!special_done && random_sent >= RANDOM_ITEMS / 2)
            begin
                // Width past the maximum clamps to 1024 columns, so a short run
                // stays in the first row and gives no result.
                mode = edge_mode_t'($urandom_range(0, 1));
                apply_setting(11'd2047, 11'd3, mode, restart, frame_px);
                run_pixels(40, 1'b1, 1'b0);
                // The width shrinks mid-row: the current column is past the new
                // last column, so the row ends there and the next row begins.
                apply_setting(11'd5, 11'd3, mode, restart, frame_px);
                run_pixels(60, restart, 1'b0);
                // A tall frame that is cut by a smaller height mid-frame: the row
                // past the new last row ends the frame with frame_last.
                apply_setting(11'd3, 11'd1500, edge_mode_t'(~mode), restart, frame_px);
                run_pixels(45, 1'b1, 1'b0);
                apply_setting(11'd3, 11'd6, edge_mode_t'(~mode), restart, frame_px);
                run_pixels(30, restart, 1'b0);
                special_done = 1'b1;
            end
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                w_raw = CFG_W'($urandom_range(0, 2));
            end
            else if (sel == 1)
            begin
                w_raw = CFG_W'($urandom_range(13, 40));
            end
            else
            begin
                w_raw = CFG_W'($urandom_range(3, 12));
            end
            h_raw = ($urandom_range(0, 6) == 0) ? CFG_W'($urandom_range(0, 2))
                                                : CFG_W'($urandom_range(3, 8));
            mode  = edge_mode_t'($urandom_range(0, 1));
            apply_setting(w_raw, h_raw, mode, restart, frame_px);
            if ($urandom_range(0, 9) < 7)
            begin
                n = $urandom_range(1, 3) * frame_px + $urandom_range(0, 5);
            end
            else
            begin
                n = $urandom_range(1, 2 * frame_px);
            end
            // The random part keeps to its share of the pixel budget.
            if (n > RANDOM_ITEMS - random_sent)
            begin
                n = RANDOM_ITEMS - random_sent;
            end
            run_pixels(n, restart || $urandom_range(0, 3) == 0, 1'b1);
            random_sent += n;
        end

        // Last part: two clean frames with no idling on either side.
        steady = 1'b1;
        apply_setting(11'd8, 11'd6, edge_mode_t'($urandom_range(0, 1)), restart, frame_px);
        run_pixels(2 * frame_px, 1'b1, 1'b0);

        wait_idle();
        repeat (END_CYCLES) @(negedge clk);
        $display("Sent %0d pixels over %0d register settings; %0d gradients checked, %0d frame ends.",
                 pixels_sent, settings_used, checked, frame_ends);
        $display("Covered both kernels, clamped sizes, frame wraps, restarts and mid-frame shrinks.");
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/pef_pkg.sv
src/pef_cfg_regs.sv
src/pef_line_buffer.sv
src/pef_window.sv
src/prewitt_edge_filter_3x3_top.sv
src/pef_checker.sv
tb/prewitt_checker.sv
tb/tb_prewitt_edge_filter_3x3_top.sv
